### rtl/spectral_triplet_shaper_macros.svh
// Assertion macros for the spectral triplet shaper.
// Used by the top level; expects clk and rst in the including scope.
`ifndef SPECTRAL_TRIPLET_SHAPER_MACROS_SVH
`define SPECTRAL_TRIPLET_SHAPER_MACROS_SVH

// Same-cycle implication.
`define STSH_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define STSH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/stsh_pkg.sv
// Shared types and constants for the spectral triplet shaper.
// No dependencies; used by stsh_div and spectral_triplet_shaper.
`timescale 1ns / 1ps

package stsh_pkg;

  localparam int AMP_WIDTH   = 16;
  localparam int PHASE_WIDTH = 16;
  localparam int Q_FRAC      = 8;   // fraction bits of the Q8.8 ratio
  localparam int RATIO_WIDTH = 16;
  localparam int SUM_WIDTH   = AMP_WIDTH + 2;      // sum of three amplitudes
  localparam int DIVIDEND_W  = SUM_WIDTH + Q_FRAC; // widest dividend (sum << 8)
  localparam int RSUM_WIDTH  = RATIO_WIDTH + 2;    // rlo + rhi + 1.0
  localparam int DIVISOR_W   = (RSUM_WIDTH > AMP_WIDTH) ? RSUM_WIDTH : AMP_WIDTH;
  localparam int PROD_WIDTH  = RATIO_WIDTH + AMP_WIDTH;

  localparam logic [RATIO_WIDTH-1:0] RATIO_MAX = '1;
  localparam logic [AMP_WIDTH-1:0]   AMP_MAX   = '1;

  typedef struct packed {
    logic [AMP_WIDTH-1:0]          ref_amp;
    logic signed [PHASE_WIDTH-1:0] ref_phase;
    logic [AMP_WIDTH-1:0]          src_amp;
    logic signed [PHASE_WIDTH-1:0] src_phase;
    logic                          last_bin;
  } in_t;

  typedef struct packed {
    logic [AMP_WIDTH-1:0]          out_amp;
    logic signed [PHASE_WIDTH-1:0] out_phase;
    logic                          run_end;
    logic                          frame_end;
  } out_t;

  // One collected bin
  typedef struct packed {
    logic [AMP_WIDTH-1:0]   ref_amp;
    logic [PHASE_WIDTH-1:0] ref_phase;
    logic [AMP_WIDTH-1:0]   src_amp;
    logic [PHASE_WIDTH-1:0] src_phase;
  } bin_t;

endpackage

### rtl/stsh_div.sv
// Restoring divider, one quotient bit per cycle, shared by all group divisions.
// Depends on stsh_pkg for operand widths.
`timescale 1ns / 1ps

module stsh_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [stsh_pkg::DIVIDEND_W-1:0]  dividend,
  input  logic [stsh_pkg::DIVISOR_W-1:0]   divisor,
  output logic                             busy,
  output logic                             done,
  output logic [stsh_pkg::DIVIDEND_W-1:0]  quotient
);

  localparam int DW = stsh_pkg::DIVIDEND_W;
  localparam int VW = stsh_pkg::DIVISOR_W;
  localparam int CW = $clog2(DW);

  logic [CW-1:0] cnt;
  logic [VW-1:0] rem;
  logic [VW-1:0] dvs;
  logic [DW-1:0] quo;
  logic [VW:0]   trial;
  logic [VW:0]   diff;
  logic          qbit;

  // One trial subtraction per cycle
  assign trial = {rem, quo[DW-1]};
  assign diff  = trial - {1'b0, dvs};
  assign qbit  = ~diff[VW];

  assign quotient = quo;

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(DW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: dividend bits shift out as quotient bits shift in
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvs <= divisor;
      quo <= dividend;
    end else if (busy) begin
      rem <= qbit ? diff[VW-1:0] : trial[VW-1:0];
      quo <= {quo[DW-2:0], qbit};
    end
  end

endmodule

### rtl/spectral_triplet_shaper.sv
// Spectral triplet shaper: a bin that neither closes a group nor the frame is stored
// and gives no result of its own; a bin that closes a group starts three divisions on
// the shared divider, three multiply steps and an output load, then gives one result
// per cycle while the output is not stalled; a frame-end partial group goes straight
// to the output load. No new bin is taken until the last result of a group is loaded.
// Synchronous reset clears the sequencer, group position and output valid.
`timescale 1ns / 1ps
`include "spectral_triplet_shaper_macros.svh"

module spectral_triplet_shaper (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  stsh_pkg::in_t    in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output stsh_pkg::out_t   out_data
);

  localparam int AW  = stsh_pkg::AMP_WIDTH;
  localparam int PW  = stsh_pkg::PHASE_WIDTH;
  localparam int QF  = stsh_pkg::Q_FRAC;
  localparam int RW  = stsh_pkg::RATIO_WIDTH;
  localparam int SW  = stsh_pkg::SUM_WIDTH;
  localparam int DW  = stsh_pkg::DIVIDEND_W;
  localparam int VW  = stsh_pkg::DIVISOR_W;
  localparam int MW  = stsh_pkg::PROD_WIDTH;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RLO  = 3'd1;
  localparam logic [2:0] S_RHI  = 3'd2;
  localparam logic [2:0] S_CEN  = 3'd3;
  localparam logic [2:0] S_MLO  = 3'd4;
  localparam logic [2:0] S_MHI  = 3'd5;
  localparam logic [2:0] S_MFIN = 3'd6;
  localparam logic [2:0] S_EMIT = 3'd7;

  logic [2:0] state;
  logic [1:0] pos;
  logic [1:0] idx;
  logic [1:0] last_idx;
  logic       last_flag;
  logic       full_grp;

  stsh_pkg::bin_t store [3];
  logic [RW-1:0]  rlo;
  logic [RW-1:0]  rhi;
  logic [AW-1:0]  res_amp [3];
  logic [MW-1:0]  prod;

  logic          accept;
  logic          emit_fire;
  logic          div_start;
  logic [DW-1:0] div_dividend;
  logic [VW-1:0] div_divisor;
  logic          div_busy;
  logic          div_done;
  logic [DW-1:0] div_q;
  logic [RW-1:0] ratio_q;
  logic [AW-1:0] cen_q;
  logic [SW-1:0] src_sum;
  logic [RW-1:0] mul_a;
  logic [AW-1:0] prod_sat;
  logic [AW-1:0] sel_amp;
  logic [PW-1:0] sel_phase;
  stsh_pkg::bin_t sel_bin;

  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign emit_fire = (state == S_EMIT) && (!out_valid || !out_stall);

  stsh_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  // Quotient saturation; a zero centre reference forces both ratios to zero
  assign ratio_q = (store[1].ref_amp == '0) ? '0 :
                   (|div_q[DW-1:RW]) ? stsh_pkg::RATIO_MAX : div_q[RW-1:0];
  assign cen_q   = (|div_q[DW-1:AW]) ? stsh_pkg::AMP_MAX : div_q[AW-1:0];
  assign src_sum = SW'(store[0].src_amp) + SW'(store[1].src_amp) + SW'(store[2].src_amp);

  // Divider operand selection per sequencer step
  always_comb begin
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    unique case (state)
      S_IDLE: begin
        if (accept && pos == 2'd2) begin
          div_start    = 1'b1;
          div_dividend = DW'(store[0].ref_amp) << QF;
          div_divisor  = VW'(store[1].ref_amp);
        end
      end
      S_RLO: begin
        if (div_done) begin
          div_start    = 1'b1;
          div_dividend = DW'(store[2].ref_amp) << QF;
          div_divisor  = VW'(store[1].ref_amp);
        end
      end
      S_RHI: begin
        if (div_done) begin
          div_start    = 1'b1;
          div_dividend = DW'(src_sum) << QF;
          div_divisor  = VW'(rlo) + VW'(ratio_q) + VW'(1 << QF);
        end
      end
      default: begin
      end
    endcase
  end

  // Side amplitude: ratio times centre, back to integer, saturated
  assign mul_a    = (state == S_MLO) ? rlo : rhi;
  assign prod_sat = (|prod[MW-1:QF+AW]) ? stsh_pkg::AMP_MAX : prod[QF+AW-1:QF];

  // Result selection and phase rule
  always_comb begin
    unique case (idx)
      2'd0:    sel_bin = store[0];
      2'd1:    sel_bin = store[1];
      default: sel_bin = store[2];
    endcase
    unique case (idx)
      2'd0:    sel_amp = full_grp ? res_amp[0] : sel_bin.src_amp;
      2'd1:    sel_amp = full_grp ? res_amp[1] : sel_bin.src_amp;
      default: sel_amp = full_grp ? res_amp[2] : sel_bin.src_amp;
    endcase
    if (sel_amp == '0)
      sel_phase = '0;
    else if (sel_bin.ref_phase != '0)
      sel_phase = sel_bin.ref_phase;
    else
      sel_phase = sel_bin.src_phase;
  end

  // Sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pos       <= '0;
      idx       <= '0;
      last_idx  <= '0;
      last_flag <= 1'b0;
      full_grp  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // Output register: load a new result or drop the accepted one
      if (emit_fire)
        out_valid <= 1'b1;
      else if (out_valid && !out_stall)
        out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            last_flag <= in_data.last_bin;
            if (pos == 2'd2) begin
              state    <= S_RLO;
              pos      <= '0;
              full_grp <= 1'b1;
            end else if (in_data.last_bin) begin
              state    <= S_EMIT;
              idx      <= '0;
              last_idx <= pos;
              pos      <= '0;
              full_grp <= 1'b0;
            end else begin
              pos <= pos + 2'd1;
            end
          end
        end
        S_RLO:  if (div_done) state <= S_RHI;
        S_RHI:  if (div_done) state <= S_CEN;
        S_CEN:  if (div_done) state <= S_MLO;
        S_MLO:  state <= S_MHI;
        S_MHI:  state <= S_MFIN;
        S_MFIN: begin
          state    <= S_EMIT;
          idx      <= '0;
          last_idx <= 2'd2;
        end
        S_EMIT: begin
          if (emit_fire) begin
            idx <= idx + 2'd1;
            if (idx == last_idx)
              state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      unique case (pos)
        2'd0:    store[0] <= {in_data.ref_amp, in_data.ref_phase,
                              in_data.src_amp, in_data.src_phase};
        2'd1:    store[1] <= {in_data.ref_amp, in_data.ref_phase,
                              in_data.src_amp, in_data.src_phase};
        default: store[2] <= {in_data.ref_amp, in_data.ref_phase,
                              in_data.src_amp, in_data.src_phase};
      endcase
    end
    if (state == S_RLO && div_done)
      rlo <= ratio_q;
    if (state == S_RHI && div_done)
      rhi <= ratio_q;
    if (state == S_CEN && div_done)
      res_amp[1] <= cen_q;
    if (state == S_MLO || state == S_MHI)
      prod <= MW'(mul_a) * MW'(res_amp[1]);
    if (state == S_MHI)
      res_amp[0] <= prod_sat;
    if (state == S_MFIN)
      res_amp[2] <= prod_sat;
    if (emit_fire) begin
      out_data.out_amp   <= sel_amp;
      out_data.out_phase <= sel_phase;
      out_data.run_end   <= (idx == last_idx);
      out_data.frame_end <= (idx == last_idx) && last_flag;
    end
  end

  // Checks
  `STSH_ASSERT_NEXT(a_group_leaves_idle, accept && (pos == 2'd2 || in_data.last_bin), state != S_IDLE, "closing bin did not start work")
  `STSH_ASSERT_IMP(a_div_only_in_div_steps, div_busy, state == S_RLO || state == S_RHI || state == S_CEN, "divider busy outside a divide step")
  `STSH_ASSERT_IMP(a_frame_end_on_run_end, out_valid && out_data.frame_end, out_data.run_end, "frame end without run end")
  `STSH_ASSERT_IMP(a_emit_index_bound, state == S_EMIT, idx <= last_idx, "emit index past group end")

endmodule

### bench/spectral_triplet_shaper_test.sv
`timescale 1ns / 1ps
// Self-checking bench for spectral_triplet_shaper: directed bins, then random frames
// under three idle/stall mixes, each result checked per field against a local predictor.
// Depends on stsh_pkg (types and widths) and the spectral_triplet_shaper RTL.

module spectral_triplet_shaper_test;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 200;
  localparam int PRINT_CAP    = 100;
  localparam int AW           = stsh_pkg::AMP_WIDTH;
  localparam int PW           = stsh_pkg::PHASE_WIDTH;

  logic           clk = 1'b0;
  logic           rst;
  logic           in_valid;
  logic           in_stall;
  stsh_pkg::in_t  in_data;
  logic           out_valid;
  logic           out_stall;
  stsh_pkg::out_t out_data;

  int send_idle_pct;
  int recv_stall_pct;
  int error_count = 0;
  int cycle_count = 0;

  // Predictor state: bins of the group being collected and how many are held
  stsh_pkg::bin_t group_bins[3];
  int unsigned    group_fill;
  stsh_pkg::out_t pending_results[$];

  spectral_triplet_shaper DUT (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Receiver stall, redrawn every cycle
  always @(negedge clk) begin
    out_stall <= !rst && ($urandom_range(99) < recv_stall_pct);
  end

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= PRINT_CAP)
      $display("ERROR @%0t: %s", $time, msg);
  endtask

  function automatic longint unsigned saturate(longint unsigned v, longint unsigned top);
    return (v > top) ? top : v;
  endfunction

  // Q8.8 ratio of a side reference amplitude to the centre one; zero centre gives zero
  function automatic longint unsigned side_ratio(longint unsigned side,
                                                 longint unsigned centre);
    if (centre == 0)
      return 0;
    return saturate((side << stsh_pkg::Q_FRAC) / centre, stsh_pkg::RATIO_MAX);
  endfunction

  // Phase rule: zero amplitude -> zero, else reference phase unless that is zero
  function automatic void queue_result(longint unsigned amp, stsh_pkg::bin_t b,
                                       logic run_end, logic frame_end);
    stsh_pkg::out_t r;
    r.out_amp = AW'(amp);
    if (amp == 0)
      r.out_phase = '0;
    else if (b.ref_phase != '0)
      r.out_phase = b.ref_phase;
    else
      r.out_phase = b.src_phase;
    r.run_end   = run_end;
    r.frame_end = frame_end;
    pending_results.push_back(r);
  endfunction

  // Expected results for one accepted bin
  function automatic void predict_bin(stsh_pkg::in_t b);
    longint unsigned rlo;
    longint unsigned rhi;
    longint unsigned sum;
    longint unsigned centre;
    int unsigned     pos;
    pos = (group_fill > 2) ? 0 : group_fill;
    group_bins[pos].ref_amp   = b.ref_amp;
    group_bins[pos].ref_phase = b.ref_phase;
    group_bins[pos].src_amp   = b.src_amp;
    group_bins[pos].src_phase = b.src_phase;
    if (pos == 2) begin
      // full group: spread the summed source amplitude by the reference ratios
      rlo = side_ratio(group_bins[0].ref_amp, group_bins[1].ref_amp);
      rhi = side_ratio(group_bins[2].ref_amp, group_bins[1].ref_amp);
      sum = longint'(group_bins[0].src_amp) + longint'(group_bins[1].src_amp)
            + longint'(group_bins[2].src_amp);
      centre = saturate((sum << stsh_pkg::Q_FRAC) / (rlo + rhi + (1 << stsh_pkg::Q_FRAC)),
                        stsh_pkg::AMP_MAX);
      queue_result(saturate((rlo * centre) >> stsh_pkg::Q_FRAC, stsh_pkg::AMP_MAX),
                   group_bins[0], 1'b0, 1'b0);
      queue_result(centre, group_bins[1], 1'b0, 1'b0);
      queue_result(saturate((rhi * centre) >> stsh_pkg::Q_FRAC, stsh_pkg::AMP_MAX),
                   group_bins[2], 1'b1, b.last_bin);
      group_fill = 0;
    end else if (b.last_bin) begin
      // partial group at frame end passes through unshaped
      for (int k = 0; k <= pos; k++)
        queue_result(group_bins[k].src_amp, group_bins[k], k == pos, k == pos);
      group_fill = 0;
    end else begin
      group_fill = pos + 1;
    end
  endfunction

  // Result checker: every accepted result against the oldest expectation
  always @(posedge clk) begin : result_check
    stsh_pkg::out_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result amp %0d phase %0d",
                                  out_data.out_amp, out_data.out_phase));
      end else begin
        want = pending_results.pop_front();
        if (out_data.out_amp !== want.out_amp)
          report_mismatch($sformatf("out_amp %0d, expected %0d",
                                    out_data.out_amp, want.out_amp));
        if (out_data.out_phase !== want.out_phase)
          report_mismatch($sformatf("out_phase %0d, expected %0d",
                                    out_data.out_phase, want.out_phase));
        if (out_data.run_end !== want.run_end)
          report_mismatch($sformatf("run_end %b, expected %b",
                                    out_data.run_end, want.run_end));
        if (out_data.frame_end !== want.frame_end)
          report_mismatch($sformatf("frame_end %b, expected %b",
                                    out_data.frame_end, want.frame_end));
      end
    end
  end

  // One input transaction; called and returns at a falling edge
  task automatic send_bin(input stsh_pkg::in_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (in_stall !== 1'b0)
      @(posedge clk);
    predict_bin(b);
    @(negedge clk);
  endtask

  function automatic stsh_pkg::in_t make_bin(int ra, int rp, int sa, int sp, bit last);
    stsh_pkg::in_t b;
    b.ref_amp   = AW'(ra);
    b.ref_phase = PW'(rp);
    b.src_amp   = AW'(sa);
    b.src_phase = PW'(sp);
    b.last_bin  = last;
    return b;
  endfunction

  // Amplitudes lean toward zero, full scale and tiny values
  function automatic logic [AW-1:0] random_amp();
    case ($urandom_range(7))
      0:       return '0;
      1:       return stsh_pkg::AMP_MAX;
      2:       return AW'($urandom_range(15));
      default: return AW'($urandom);
    endcase
  endfunction

  function automatic logic [PW-1:0] random_phase();
    case ($urandom_range(7))
      0, 1:    return '0;
      2:       return {1'b1, {(PW-1){1'b0}}};
      3:       return {1'b0, {(PW-1){1'b1}}};
      default: return PW'($urandom);
    endcase
  endfunction

  // Ordinary groups, phase extremes, frame end on a full group
  task automatic test_group_shaping();
    send_bin(make_bin(100, 1000, 1000, -5, 0));
    send_bin(make_bin(200, -32768, 2000, 7, 0));
    send_bin(make_bin(300, 32767, 3000, 9, 0));
    send_bin(make_bin(65535, 0, 65535, -32768, 0));
    send_bin(make_bin(40000, 0, 0, 32767, 0));
    send_bin(make_bin(0, -1, 12345, 0, 1));
  endtask

  // Zero reference centre, and a group that is zero throughout
  task automatic test_zero_centre();
    send_bin(make_bin(500, 11, 65535, 22, 0));
    send_bin(make_bin(0, 33, 65535, 44, 0));
    send_bin(make_bin(700, 55, 65535, 66, 0));
    repeat (3) send_bin(make_bin(0, 0, 0, 0, 0));
  endtask

  // Ratio clamp, then side amplitude clamp
  task automatic test_saturation();
    send_bin(make_bin(65535, 1, 65535, 2, 0));
    send_bin(make_bin(1, 3, 65535, 4, 0));
    send_bin(make_bin(65535, 5, 65535, 6, 0));
    send_bin(make_bin(65535, -9, 65535, 8, 0));
    send_bin(make_bin(256, 0, 65535, -10, 0));
    send_bin(make_bin(0, 12, 65535, 14, 0));
  endtask

  // Frame ends after one and after two bins of a group
  task automatic test_partial_frames();
    send_bin(make_bin(10, 0, 777, -300, 1));
    send_bin(make_bin(10, 5, 0, 9, 1));
    send_bin(make_bin(20, -7, 65535, 1, 0));
    send_bin(make_bin(30, 0, 1, -2, 1));
  endtask

  // Random frames of random length; rarely an early frame end mid-frame
  task automatic test_random_traffic(input int count);
    int            sent;
    int            frame_len;
    stsh_pkg::in_t b;
    sent = 0;
    while (sent < count) begin
      frame_len = ($urandom_range(5) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 15);
      for (int k = 0; k < frame_len && sent < count; k++) begin
        b.ref_amp   = random_amp();
        b.ref_phase = random_phase();
        b.src_amp   = random_amp();
        b.src_phase = random_phase();
        b.last_bin  = (k == frame_len - 1) || ($urandom_range(49) == 0);
        send_bin(b);
        sent++;
      end
    end
  endtask

  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    in_data        = '0;
    out_stall      = 1'b0;
    send_idle_pct  = 28;
    recv_stall_pct = 55;
    group_fill     = 0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    test_group_shaping();
    test_zero_centre();
    test_saturation();
    test_partial_frames();
    test_random_traffic(130);

    send_idle_pct  = 55;
    recv_stall_pct = 28;
    test_random_traffic(125);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random_traffic(125);

    // Drain: all expected results, then a quiet stretch for stray ones
    in_valid <= 1'b0;
    while (pending_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
